// File: design/hsfd_pkg.sv
// Package for the humidity sensor frame decoder.
// Holds the word types, frame position codes, CRC-8 and scaling constants.
// No dependencies.
`default_nettype none

package hsfd_pkg;

  // One received byte of a measurement frame
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  // One decoded measurement
  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [9:0]         humidity_tenths;
    logic               frame_status;
  } out_word_t;

  // Position of a byte within the six-byte frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } frame_pos_t;

  // Frame status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // CRC-8, MSB first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling: temp = raw*1750/65535 - 450, hum = raw*1000/65535
  localparam logic [10:0]        TEMP_SPAN   = 11'd1750;
  localparam logic signed [11:0] TEMP_OFFSET = 12'sd450;
  localparam logic [9:0]         HUM_SPAN    = 10'd1000;
  localparam logic [16:0]        FULL_SCALE  = 17'd65535;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/humidity_sensor_frame_decoder_core.sv
// Humidity sensor frame decoder: CRC check and scaling of six-byte frames.
// Depends on hsfd_pkg (word types, position codes, CRC function, constants).
//
//   channel  | direction | handshake                    | word
//   ---------+-----------+------------------------------+-----------------------
//   byte     | in        | byte_valid / byte_ready      | byte_word   (in_word_t)
//   result   | out       | result_valid / result_ready  | result_word (out_word_t)
//
// One byte per cycle while no sixth byte is stalled. The input register holds a byte while the
// CRC step and the frame position logic act on it; the sixth byte of a frame also drives
// the two constant multipliers and loads the result register when it leaves the input
// register. Synchronous reset clears the position, CRC, frame word registers and valid
// flags. When the result register is full and not taken, a sixth byte waits in the input
// register and holds off the next byte; any other staged byte moves on regardless of the
// result side.
`default_nettype none

module humidity_sensor_frame_decoder_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire hsfd_pkg::in_word_t  byte_word,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output hsfd_pkg::out_word_t    result_word
);

  import hsfd_pkg::*;

  // Input register
  logic     stg_valid;
  in_word_t stg_word;

  // Frame state
  frame_pos_t byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] temperature_word, temperature_word_next;
  logic        temperature_crc_good, temperature_crc_good_next;
  logic [7:0]  humidity_high_byte, humidity_high_byte_next;
  logic [7:0]  humidity_low_byte, humidity_low_byte_next;

  frame_pos_t pos_eff;
  logic       emit;
  logic       adv;
  logic [7:0] crc_step;
  logic       frame_ok;
  out_word_t  res;

  // Scaling datapath
  logic [26:0]        t_prod;
  logic [16:0]        t_fold;
  logic [10:0]        t_q;
  logic signed [11:0] t_val;
  logic [15:0]        h_raw;
  logic [25:0]        h_prod;
  logic [16:0]        h_fold;
  logic [9:0]         h_q;

  // Position of the staged byte: frame start or a stray count restarts the frame
  always_comb begin
    if (stg_word.frame_start || (byte_position > POS_H_CRC)) begin
      pos_eff = POS_T_HI;
    end else begin
      pos_eff = byte_position;
    end
  end

  assign emit       = (pos_eff == POS_H_CRC);
  assign adv        = stg_valid && (!emit || !result_valid || result_ready);
  assign byte_ready = !stg_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (byte_ready) begin
      stg_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      stg_word <= byte_word;
    end
  end

  // CRC step; the word's first byte starts from the init value
  assign crc_step = crc8_byte((pos_eff == POS_T_HI || pos_eff == POS_H_HI) ?
                              CRC_INIT : running_crc, stg_word.data_byte);

  // Next frame state
  always_comb begin
    byte_position_next        = byte_position;
    running_crc_next          = running_crc;
    temperature_word_next     = temperature_word;
    temperature_crc_good_next = temperature_crc_good;
    humidity_high_byte_next   = humidity_high_byte;
    humidity_low_byte_next    = humidity_low_byte;
    if (adv) begin
      case (pos_eff)
        POS_T_HI: begin
          running_crc_next      = crc_step;
          temperature_word_next = {stg_word.data_byte, 8'h00};
          byte_position_next    = POS_T_LO;
        end
        POS_T_LO: begin
          running_crc_next      = crc_step;
          temperature_word_next = {temperature_word[15:8], stg_word.data_byte};
          byte_position_next    = POS_T_CRC;
        end
        POS_T_CRC: begin
          temperature_crc_good_next = (running_crc == stg_word.data_byte);
          running_crc_next          = CRC_INIT;
          byte_position_next        = POS_H_HI;
        end
        POS_H_HI: begin
          running_crc_next        = crc_step;
          humidity_high_byte_next = stg_word.data_byte;
          byte_position_next      = POS_H_LO;
        end
        POS_H_LO: begin
          running_crc_next       = crc_step;
          humidity_low_byte_next = stg_word.data_byte;
          byte_position_next     = POS_H_CRC;
        end
        POS_H_CRC: begin
          running_crc_next   = CRC_INIT;
          byte_position_next = POS_T_HI;
        end
        default: begin
          byte_position_next = byte_position;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= POS_T_HI;
      running_crc          <= CRC_INIT;
      temperature_crc_good <= 1'b0;
    end else begin
      byte_position        <= byte_position_next;
      running_crc          <= running_crc_next;
      temperature_crc_good <= temperature_crc_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_word   <= '0;
      humidity_high_byte <= '0;
      humidity_low_byte  <= '0;
    end else begin
      temperature_word   <= temperature_word_next;
      humidity_high_byte <= humidity_high_byte_next;
      humidity_low_byte  <= humidity_low_byte_next;
    end
  end

  // Scaling: x/65535 = hi + lo_fold check, where x = hi*65535 + (hi + lo)
  always_comb begin
    t_prod = 27'(temperature_word) * 27'(TEMP_SPAN);
    t_fold = 17'(t_prod[26:16]) + 17'(t_prod[15:0]);
    t_q    = t_prod[26:16] + 11'(t_fold >= FULL_SCALE);
    t_val  = signed'({1'b0, t_q}) - TEMP_OFFSET;

    h_raw  = {humidity_high_byte, humidity_low_byte};
    h_prod = 26'(h_raw) * 26'(HUM_SPAN);
    h_fold = 17'(h_prod[25:16]) + 17'(h_prod[15:0]);
    h_q    = h_prod[25:16] + 10'(h_fold >= FULL_SCALE);
  end

  // Result assembly, zeroed on CRC failure
  assign frame_ok = temperature_crc_good && (running_crc == stg_word.data_byte);

  always_comb begin
    if (frame_ok) begin
      res.temperature_tenths = t_val;
      res.humidity_tenths    = h_q;
      res.frame_status       = STATUS_OK;
    end else begin
      res.temperature_tenths = '0;
      res.humidity_tenths    = '0;
      res.frame_status       = STATUS_CRC_ERR;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      result_word <= res;
    end
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_word.frame_status == STATUS_CRC_ERR)) |->
      (result_word.temperature_tenths == 12'sd0 && result_word.humidity_tenths == 10'd0))
    else $error("error word carries nonzero values");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_word.frame_status == STATUS_OK)) |->
      (result_word.humidity_tenths <= HUM_SPAN &&
       result_word.temperature_tenths >= -TEMP_OFFSET &&
       result_word.temperature_tenths <= 12'sd1300))
    else $error("scaled value out of range");

  a_crc_init: assert property (@(posedge clk) disable iff (rst)
    (byte_position == POS_T_HI || byte_position == POS_H_HI) |-> (running_crc == CRC_INIT))
    else $error("CRC not reinitialized at word boundary");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !adv) |=> (stg_valid && $stable(stg_word)))
    else $error("staged byte lost while stalled");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(adv && emit))
    else $error("result without a sixth byte");

endmodule

`default_nettype wire
